@@ rtl/core/quad_motor_pwm_direction_macros.svh @@
// Assertion macros shared by the quad motor PWM RTL.
`ifndef QUAD_MOTOR_PWM_DIRECTION_MACROS_SVH
`define QUAD_MOTOR_PWM_DIRECTION_MACROS_SVH
`ifndef SYNTHESIS
`define QMPD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define QMPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QMPD_ASSERT_SAME(lbl, ante, cons, msg)
`define QMPD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/qmpd_pkg.sv @@
// Shared types and constants of the quad motor PWM driver.
package qmpd_pkg;

    localparam int MOTOR_COUNT  = 4;
    localparam int COUNT_W      = 16;
    localparam int LEVEL_W      = 5;
    localparam int STEP_W       = 12;
    localparam int IDX_W        = 3;
    localparam int POWER_W      = 8;
    localparam int DRIVE_W      = 8;

    localparam int POWER_LIMIT  = 100;
    localparam int POWER_STEPS  = 20;
    localparam int PERIOD_RESET = 4000;
    localparam int STEP_RESET   = PERIOD_RESET / POWER_STEPS;

    // magnitude / 5 for 0..100: (mag * 205) >> 10
    localparam int DIV5_RECIP   = 205;
    localparam int DIV5_SHIFT   = 10;
    // period / 20 as (period >> 2) / 5 = ((period >> 2) * 52429) >> 18
    localparam int STEP_RECIP   = 52429;
    localparam int STEP_SHIFT   = 18;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_SET  = 1'b1
    } t_op;

    typedef struct packed {
        logic                      tick;
        logic                      set;
        logic [IDX_W-1:0]          idx;
        logic signed [POWER_W-1:0] power;
    } t_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [STEP_W-1:0]  step;
    } t_phase;

endpackage

@@ rtl/core/quad_motor_pwm_direction.sv @@
// Top level of the quad motor PWM driver: word registers and handshakes.
// A word's result passes the input register, then the result register, on its way
// to the output; one word per cycle sustained while the output is not stalled.
// The enable compare for all motors and the counter step sit in one stage.
// A stalled result still lets one more input word into the input register.
// Reset (synchronous, active low): levels, directions, count, latched drive
// zero; period 4000 ticks; cfg writes are always accepted.
`include "quad_motor_pwm_direction_macros.svh"
module quad_motor_pwm_direction (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [2:0] motor_index, [10:3] power_and_direction, [15:11] zero
    input  logic [15:0]                      i_s_axis_tdata,
    // [0] operation
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [7:0] drive_byte
    output logic [qmpd_pkg::DRIVE_W-1:0]     o_m_axis_tdata,
    // [0] period_start
    output logic                             o_m_axis_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [qmpd_pkg::COUNT_W-1:0]     i_cfg_data
);
    import qmpd_pkg::*;

    logic                      r_in_valid;
    t_op                       r_in_op;
    logic [IDX_W-1:0]          r_in_idx;
    logic signed [POWER_W-1:0] r_in_power;

    logic                      r_out_valid;
    logic [DRIVE_W-1:0]        r_out_data;
    logic                      r_out_start;

    logic                      advance;
    logic                      in_take;
    t_cmd                      cmd;
    t_phase                    phase;
    logic [DRIVE_W-1:0]        drive;
    logic [DRIVE_W-1:0]        latched;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_comb begin
        cmd.tick  = advance && (r_in_op == OP_TICK);
        // sets naming a missing motor change nothing
        cmd.set   = advance && (r_in_op == OP_SET) && (r_in_idx < IDX_W'(MOTOR_COUNT));
        cmd.idx   = r_in_idx;
        cmd.power = r_in_power;
    end

    qmpd_period_timer u_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_phase     (phase)
    );

    qmpd_motor_bank u_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_phase   (phase),
        .o_drive   (drive),
        .o_latched (latched)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op    <= t_op'(i_s_axis_tuser);
            r_in_idx   <= i_s_axis_tdata[IDX_W-1:0];
            r_in_power <= i_s_axis_tdata[IDX_W +: POWER_W];
        end
        if (advance) begin
            if (r_in_op == OP_TICK) begin
                r_out_data  <= drive;
                r_out_start <= (phase.count == '0);
            end else begin
                r_out_data  <= latched;
                r_out_start <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_start;

    `QMPD_ASSERT_NEXT(a_skid_fill, in_take && r_out_valid && !i_m_axis_tready,
                      r_in_valid && r_out_valid, "word lost while result stalled")

endmodule

@@ rtl/core/qmpd_period_timer.sv @@
// PWM period counter and period-step register.
`include "quad_motor_pwm_direction_macros.svh"
module qmpd_period_timer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [qmpd_pkg::COUNT_W-1:0]     i_cfg_data,
    input  qmpd_pkg::t_cmd                   i_cmd,
    output qmpd_pkg::t_phase                 o_phase
);
    import qmpd_pkg::*;

    localparam int PROD_W = COUNT_W - 2 + 16;

    logic [COUNT_W-1:0] r_period, n_period;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [PROD_W-1:0]  step_prod;
    logic [COUNT_W:0]   inc;

    assign step_prod = PROD_W'(i_cfg_data[COUNT_W-1:2]) * PROD_W'(STEP_RECIP);
    assign inc       = {1'b0, r_count} + (COUNT_W+1)'(1);

    always_comb begin
        n_period = r_period;
        n_step   = r_step;
        n_count  = r_count;
        if (i_cfg_valid) begin
            n_period = i_cfg_data;
            n_step   = step_prod[STEP_SHIFT +: STEP_W];
        end
        if (i_cmd.set) begin
            n_count = '0;
        end else if (i_cmd.tick) begin
            // wrap also catches a period shrunk below the count
            n_count = (inc >= {1'b0, r_period}) ? '0 : inc[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= COUNT_W'(PERIOD_RESET);
            r_step   <= STEP_W'(STEP_RESET);
            r_count  <= '0;
        end else begin
            r_period <= n_period;
            r_step   <= n_step;
            r_count  <= n_count;
        end
    end

    assign o_phase.count = r_count;
    assign o_phase.step  = r_step;

    `QMPD_ASSERT_NEXT(a_set_restarts, i_cmd.set, r_count == '0, "set did not restart period")
    `QMPD_ASSERT_NEXT(a_count_holds, !i_cmd.set && !i_cmd.tick, $stable(r_count),
                      "period count moved without a word")

endmodule

@@ rtl/core/qmpd_motor_bank.sv @@
// Per-motor power levels, direction bits, enable compare and latched drive byte.
`include "quad_motor_pwm_direction_macros.svh"
module qmpd_motor_bank (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  qmpd_pkg::t_cmd                   i_cmd,
    input  qmpd_pkg::t_phase                 i_phase,
    output logic [qmpd_pkg::DRIVE_W-1:0]     o_drive,
    output logic [qmpd_pkg::DRIVE_W-1:0]     o_latched
);
    import qmpd_pkg::*;

    localparam int MAG_W  = 7;
    localparam int QPROD_W = MAG_W + 8;
    localparam int THR_W  = LEVEL_W + STEP_W;

    logic [LEVEL_W-1:0]     r_level [MOTOR_COUNT];
    logic [LEVEL_W-1:0]     n_level [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] r_dir, n_dir;
    logic [DRIVE_W-1:0]     r_latched;

    logic signed [POWER_W-1:0] clamped;
    logic [MAG_W-1:0]          mag;
    logic [QPROD_W-1:0]        qprod;
    logic [LEVEL_W-1:0]        new_level;
    logic [THR_W-1:0]          thr [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0]    en;

    always_comb begin
        if (i_cmd.power > POWER_W'(POWER_LIMIT)) begin
            clamped = POWER_W'(POWER_LIMIT);
        end else if (i_cmd.power < -POWER_W'(POWER_LIMIT)) begin
            clamped = -POWER_W'(POWER_LIMIT);
        end else begin
            clamped = i_cmd.power;
        end
        mag       = clamped[POWER_W-1] ? MAG_W'(-clamped) : MAG_W'(clamped);
        qprod     = QPROD_W'(mag) * QPROD_W'(DIV5_RECIP);
        new_level = qprod[DIV5_SHIFT +: LEVEL_W];
    end

    always_comb begin
        n_dir = r_dir;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            n_level[i] = r_level[i];
            if (i_cmd.set && i_cmd.idx == IDX_W'(i)) begin
                n_level[i] = new_level;
                n_dir[i]   = ~clamped[POWER_W-1];  // zero power counts as forward
            end
        end
    end

    always_comb begin
        o_drive = '0;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
            thr[i] = THR_W'(r_level[i]) * THR_W'(i_phase.step);
            if (r_level[i] == '0) begin
                en[i] = 1'b0;
            end else if (r_level[i] >= LEVEL_W'(POWER_STEPS)) begin
                en[i] = 1'b1;
            end else begin
                en[i] = THR_W'(i_phase.count) < thr[i];
            end
            o_drive[2*i]   = en[i];
            o_drive[2*i+1] = r_dir[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                r_level[i] <= '0;
            end
            r_dir     <= '0;
            r_latched <= '0;
        end else begin
            r_level <= n_level;
            r_dir   <= n_dir;
            if (i_cmd.tick) begin
                r_latched <= o_drive;
            end
        end
    end

    assign o_latched = r_latched;

    `QMPD_ASSERT_NEXT(a_tick_latches, i_cmd.tick, r_latched == $past(o_drive),
                      "tick did not latch the drive byte")

endmodule
